### rtl/bsd_pkg.sv
package bsd_pkg;

    localparam logic [3:0] ST_PIXEL     = 4'd0;
    localparam logic [3:0] ST_SIGNATURE = 4'd1;
    localparam logic [3:0] ST_HDR_SIZE  = 4'd2;
    localparam logic [3:0] ST_PLANES    = 4'd3;
    localparam logic [3:0] ST_DEPTH     = 4'd4;
    localparam logic [3:0] ST_COMPRESS  = 4'd5;
    localparam logic [3:0] ST_DIMS      = 4'd6;
    localparam logic [3:0] ST_OFFSET    = 4'd7;
    localparam logic [3:0] ST_TRUNC     = 4'd8;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] INFO_SIZE_MIN = 32'd40;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;

    // byte positions at which a header field is complete
    localparam logic [5:0] POS_SIGNATURE = 6'd1;
    localparam logic [5:0] POS_OFFSET    = 6'd13;
    localparam logic [5:0] POS_INFO_SIZE = 6'd17;
    localparam logic [5:0] POS_WIDTH     = 6'd21;
    localparam logic [5:0] POS_HEIGHT    = 6'd25;
    localparam logic [5:0] POS_PLANES    = 6'd27;
    localparam logic [5:0] POS_DEPTH     = 6'd29;
    localparam logic [5:0] POS_COMPRESS  = 6'd33;
    localparam logic [5:0] POS_HDR_END   = 6'd53;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic [3:0]  status;
        logic        last;
    } res_t;

endpackage

### rtl/bsd_hdr.sv
module bsd_hdr import bsd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int WW         = 13,
    parameter int HW         = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    byte_in,
    input  logic          end_in,
    output logic          pix_phase,
    output logic [WW-1:0] img_width,
    output logic [HW-1:0] img_height,
    output logic          top_down,
    output logic          res_valid,
    output res_t          res
);

    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   gather_reg, gather_next;
    logic [31:0]   pstart_reg, pstart_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic          topdown_reg, topdown_next;
    logic [3:0]    pend_reg, pend_next;

    logic [31:0] v;
    logic [31:0] mag;
    logic        hdr_phase;
    logic        skip_phase;
    logic        fire;
    logic [3:0]  fire_code;

    function automatic logic [3:0] note(input logic [3:0] pend, input logic [3:0] code);
        return (pend == ST_PIXEL || code < pend) ? code : pend;
    endfunction

    assign v          = {byte_in, gather_reg[31:8]};
    assign mag        = v[31] ? (~v + 32'd1) : v;
    assign hdr_phase  = pos_reg < HEADER_BYTES;
    assign skip_phase = !hdr_phase && (pos_reg < pstart_reg);
    assign pix_phase  = !hdr_phase && !skip_phase;

    assign img_width  = width_reg;
    assign img_height = height_reg;
    assign top_down   = topdown_reg;

    always_comb begin
        pos_next     = pos_reg;
        gather_next  = gather_reg;
        pstart_next  = pstart_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        topdown_next = topdown_reg;
        pend_next    = pend_reg;
        fire         = 1'b0;
        fire_code    = ST_PIXEL;
        if (step && hdr_phase) begin
            gather_next = v;
            pos_next    = pos_reg + 32'd1;
            case (pos_reg[5:0])
                POS_SIGNATURE: begin
                    if (v[31:16] != BMP_SIGNATURE) pend_next = note(pend_reg, ST_SIGNATURE);
                end
                POS_OFFSET: begin
                    pstart_next = v;
                    if (pend_reg != ST_PIXEL) begin
                        fire      = 1'b1;
                        fire_code = pend_reg;
                    end
                end
                POS_INFO_SIZE: begin
                    if (v < INFO_SIZE_MIN) pend_next = note(pend_reg, ST_HDR_SIZE);
                end
                POS_WIDTH: begin
                    if (v == 32'd0 || v[31] || v > MAX_W32) begin
                        pend_next = note(pend_reg, ST_DIMS);
                    end else begin
                        width_next = v[WW-1:0];
                    end
                end
                POS_HEIGHT: begin
                    topdown_next = v[31];
                    if (mag == 32'd0 || mag > MAX_H32) begin
                        pend_next = note(pend_reg, ST_DIMS);
                    end else begin
                        height_next = mag[HW-1:0];
                    end
                end
                POS_PLANES: begin
                    if (v[31:16] != BMP_PLANES) pend_next = note(pend_reg, ST_PLANES);
                end
                POS_DEPTH: begin
                    if (v[31:16] != BMP_DEPTH) pend_next = note(pend_reg, ST_DEPTH);
                end
                POS_COMPRESS: begin
                    if (v != 32'd0) pend_next = note(pend_reg, ST_COMPRESS);
                end
                POS_HDR_END: begin
                    if (pend_reg != ST_PIXEL) begin
                        fire      = 1'b1;
                        fire_code = pend_reg;
                    end else if (pstart_reg < HEADER_BYTES) begin
                        fire      = 1'b1;
                        fire_code = ST_OFFSET;
                    end
                end
                default: begin
                end
            endcase
            // a header error on this byte wins over the early end
            if (!fire && end_in) begin
                fire      = 1'b1;
                fire_code = ST_TRUNC;
            end
        end else if (step && skip_phase) begin
            pos_next = pos_reg + 32'd1;
            if (end_in) begin
                fire      = 1'b1;
                fire_code = ST_TRUNC;
            end
        end
    end

    always_comb begin
        res        = '0;
        res.status = fire_code;
        res.last   = 1'b1;
        res_valid  = fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            gather_reg  <= '0;
            pstart_reg  <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            topdown_reg <= 1'b0;
            pend_reg    <= ST_PIXEL;
        end else begin
            pos_reg     <= pos_next;
            gather_reg  <= gather_next;
            pstart_reg  <= pstart_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            topdown_reg <= topdown_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

### rtl/bsd_pix.sv
module bsd_pix import bsd_pkg::*; #(
    parameter int WW = 13,
    parameter int HW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    byte_in,
    input  logic          end_in,
    input  logic [WW-1:0] img_width,
    input  logic [HW-1:0] img_height,
    input  logic          top_down,
    output logic          res_valid,
    output res_t          res
);

    localparam int CXW = (WW > 12) ? WW : 12;
    localparam int RXW = (HW > 12) ? HW : 12;

    logic [1:0]    pad_reg, pad_next;
    logic [1:0]    bip_reg, bip_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;
    logic [WW-1:0] col_reg, col_next;
    logic [HW-1:0] frow_reg, frow_next;

    logic [WW:0]   col_inc;
    logic [HW:0]   frow_inc;
    logic          final_px;
    logic [HW-1:0] row_px;
    logic [CXW-1:0] col_ext;
    logic [RXW-1:0] row_ext;

    assign col_inc  = {1'b0, col_reg} + {{WW{1'b0}}, 1'b1};
    assign frow_inc = {1'b0, frow_reg} + {{HW{1'b0}}, 1'b1};
    assign final_px = (frow_inc == {1'b0, img_height}) && (col_inc == {1'b0, img_width});
    assign row_px   = top_down ? frow_reg : (img_height - {{(HW-1){1'b0}}, 1'b1} - frow_reg);
    assign col_ext  = CXW'(col_reg);
    assign row_ext  = RXW'(row_px);

    always_comb begin
        pad_next   = pad_reg;
        bip_next   = bip_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        col_next   = col_reg;
        frow_next  = frow_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.status = ST_TRUNC;
        res.last   = 1'b1;
        if (step) begin
            if (pad_reg != 2'd0) begin
                pad_next  = pad_reg - 2'd1;
                res_valid = end_in;
            end else if (bip_reg == 2'd0) begin
                blue_next = byte_in;
                bip_next  = 2'd1;
                res_valid = end_in;
            end else if (bip_reg == 2'd1) begin
                green_next = byte_in;
                bip_next   = 2'd2;
                res_valid  = end_in;
            end else begin
                bip_next  = 2'd0;
                res_valid = 1'b1;
                if (!(end_in && !final_px)) begin
                    res.red    = byte_in;
                    res.green  = green_reg;
                    res.blue   = blue_reg;
                    res.column = col_ext[11:0];
                    res.row    = row_ext[11:0];
                    res.status = ST_PIXEL;
                    res.last   = final_px;
                    if (!final_px) begin
                        // wrap the column and skip the row padding
                        if (col_inc == {1'b0, img_width}) begin
                            col_next  = '0;
                            frow_next = frow_inc[HW-1:0];
                            pad_next  = img_width[1:0];
                        end else begin
                            col_next = col_inc[WW-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg   <= 2'd0;
            bip_reg   <= 2'd0;
            col_reg   <= '0;
            frow_reg  <= '0;
        end else begin
            pad_reg   <= pad_next;
            bip_reg   <= bip_next;
            col_reg   <= col_next;
            frow_reg  <= frow_next;
        end
    end

    always_ff @(posedge aclk) begin
        blue_reg  <= blue_next;
        green_reg <= green_next;
    end

endmodule

### rtl/bsd_outbuf.sv
module bsd_outbuf import bsd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_data,
    output logic has_room,
    input  logic pop,
    output logic out_valid,
    output res_t out_data
);

    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;

    assign has_room  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = head_reg;

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        case (cnt_reg)
            2'd0: begin
                if (push) begin
                    head_next = push_data;
                    cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = push_data;
                end else if (push) begin
                    tail_next = push_data;
                    cnt_next  = 2'd2;
                end else if (pop) begin
                    cnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = tail_reg;
                    cnt_next  = 2'd1;
                end
            end
            default: begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

### rtl/bmp24_stream_decoder_top.sv
// A result is registered in the output buffer and offered on the m_ side from there.
// Throughput: one byte per cycle while s_tready is high; header gathering, offset skip
// and pixel assembly each update their state in the cycle in which the byte is taken.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset: synchronous, active low; clears the parse state and drops buffered results.
module bmp24_stream_decoder_top import bsd_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                   // [35:24] column, [47:36] row
    output logic [3:0]  m_tuser,   // [3:0] status
    output logic        m_tlast
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic          stopped_reg, stopped_next;
    logic          step;
    logic          pix_phase;
    logic [WW-1:0] img_width;
    logic [HW-1:0] img_height;
    logic          top_down;
    logic          hdr_valid, pix_valid, res_valid;
    res_t          hdr_res, pix_res, res, out_res;

    assign step = s_tvalid && s_tready && !stopped_reg;

    bsd_hdr #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .WW        (WW),
        .HW        (HW)
    ) u_hdr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_in   (s_tdata),
        .end_in    (s_tlast),
        .pix_phase (pix_phase),
        .img_width (img_width),
        .img_height(img_height),
        .top_down  (top_down),
        .res_valid (hdr_valid),
        .res       (hdr_res)
    );

    bsd_pix #(
        .WW(WW),
        .HW(HW)
    ) u_pix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step && pix_phase),
        .byte_in   (s_tdata),
        .end_in    (s_tlast),
        .img_width (img_width),
        .img_height(img_height),
        .top_down  (top_down),
        .res_valid (pix_valid),
        .res       (pix_res)
    );

    assign res_valid = pix_phase ? pix_valid : hdr_valid;
    assign res       = pix_phase ? pix_res : hdr_res;

    // halt on an error or on the final pixel
    assign stopped_next = stopped_reg || (res_valid && res.last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
        end else begin
            stopped_reg <= stopped_next;
        end
    end

    bsd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_valid),
        .push_data(res),
        .has_room (s_tready),
        .pop      (m_tvalid && m_tready),
        .out_valid(m_tvalid),
        .out_data (out_res)
    );

    assign m_tdata = {out_res.row, out_res.column, out_res.blue, out_res.green, out_res.red};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

    a_no_result_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> !res_valid)
        else $error("result produced after decoding stopped");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_PIXEL) |-> res.last)
        else $error("error result without last");

    a_error_no_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status != ST_PIXEL) |->
        (res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0))
        else $error("error result carries pixel data");

    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last) |=> stopped_reg)
        else $error("decoder kept running after last result");

endmodule
